// File: rtl/rvdec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_pkg: shared types and constants of the RV32I instruction decoder
// Major opcodes, mnemonic indexes, status codes, the format class that the
// front end attaches to each item, and the funct3 lookup tables.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    // major opcodes (bits 6..0)
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FUNC   = 2'd1;
    localparam logic [1:0] ST_OPCODE = 2'd2;

    // mnemonic indexes
    localparam logic [5:0] MN_ADD    = 6'd0;
    localparam logic [5:0] MN_SUB    = 6'd1;
    localparam logic [5:0] MN_AND    = 6'd2;
    localparam logic [5:0] MN_OR     = 6'd3;
    localparam logic [5:0] MN_XOR    = 6'd4;
    localparam logic [5:0] MN_SLL    = 6'd5;
    localparam logic [5:0] MN_SRL    = 6'd6;
    localparam logic [5:0] MN_SRA    = 6'd7;
    localparam logic [5:0] MN_SLT    = 6'd8;
    localparam logic [5:0] MN_SLTU   = 6'd9;
    localparam logic [5:0] MN_SLLI   = 6'd10;
    localparam logic [5:0] MN_SRLI   = 6'd11;
    localparam logic [5:0] MN_SRAI   = 6'd12;
    localparam logic [5:0] MN_ADDI   = 6'd13;
    localparam logic [5:0] MN_ANDI   = 6'd14;
    localparam logic [5:0] MN_ORI    = 6'd15;
    localparam logic [5:0] MN_XORI   = 6'd16;
    localparam logic [5:0] MN_SLTI   = 6'd17;
    localparam logic [5:0] MN_SLTIU  = 6'd18;
    localparam logic [5:0] MN_LB     = 6'd19;
    localparam logic [5:0] MN_LBU    = 6'd20;
    localparam logic [5:0] MN_LH     = 6'd21;
    localparam logic [5:0] MN_LHU    = 6'd22;
    localparam logic [5:0] MN_LW     = 6'd23;
    localparam logic [5:0] MN_JALR   = 6'd24;
    localparam logic [5:0] MN_EBREAK = 6'd25;
    localparam logic [5:0] MN_ECALL  = 6'd26;
    localparam logic [5:0] MN_SB     = 6'd27;
    localparam logic [5:0] MN_SH     = 6'd28;
    localparam logic [5:0] MN_SW     = 6'd29;
    localparam logic [5:0] MN_BEQ    = 6'd30;
    localparam logic [5:0] MN_BGE    = 6'd31;
    localparam logic [5:0] MN_BGEU   = 6'd32;
    localparam logic [5:0] MN_BLT    = 6'd33;
    localparam logic [5:0] MN_BLTU   = 6'd34;
    localparam logic [5:0] MN_BNE    = 6'd35;
    localparam logic [5:0] MN_JAL    = 6'd36;
    localparam logic [5:0] MN_AUIPC  = 6'd37;
    localparam logic [5:0] MN_LUI    = 6'd38;

    // queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        FMT_OP     = 4'd0,
        FMT_OPIMM  = 4'd1,
        FMT_LOAD   = 4'd2,
        FMT_JALR   = 4'd3,
        FMT_SYSTEM = 4'd4,
        FMT_STORE  = 4'd5,
        FMT_BRANCH = 4'd6,
        FMT_JAL    = 4'd7,
        FMT_AUIPC  = 4'd8,
        FMT_LUI    = 4'd9,
        FMT_BAD    = 4'd10
    } fmt_t;

    typedef struct packed {
        logic [31:0] word;
        fmt_t        fmt;
    } fe_item_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] mn;
    } mn_lookup_t;

    function automatic mn_lookup_t r_lookup(input logic [2:0] f3);
        mn_lookup_t lk;
        lk.ok = 1'b1;
        case (f3)
            3'd0: lk.mn = MN_ADD;
            3'd1: lk.mn = MN_SLL;
            3'd2: lk.mn = MN_SLT;
            3'd3: lk.mn = MN_SLTU;
            3'd4: lk.mn = MN_XOR;
            3'd5: lk.mn = MN_SRL;
            3'd6: lk.mn = MN_OR;
            default: lk.mn = MN_AND;
        endcase
        return lk;
    endfunction

    function automatic mn_lookup_t ia_lookup(input logic [2:0] f3);
        mn_lookup_t lk;
        lk.ok = 1'b1;
        case (f3)
            3'd0: lk.mn = MN_ADDI;
            3'd1: lk.mn = MN_SLLI;
            3'd2: lk.mn = MN_SLTI;
            3'd3: lk.mn = MN_SLTIU;
            3'd4: lk.mn = MN_XORI;
            3'd5: lk.mn = MN_SRLI;
            3'd6: lk.mn = MN_ORI;
            default: lk.mn = MN_ANDI;
        endcase
        return lk;
    endfunction

    function automatic mn_lookup_t ld_lookup(input logic [2:0] f3);
        mn_lookup_t lk;
        lk.ok = 1'b1;
        case (f3)
            3'd0: lk.mn = MN_LB;
            3'd1: lk.mn = MN_LH;
            3'd2: lk.mn = MN_LW;
            3'd4: lk.mn = MN_LBU;
            3'd5: lk.mn = MN_LHU;
            default: begin
                lk.ok = 1'b0;
                lk.mn = MN_ADD;
            end
        endcase
        return lk;
    endfunction

    function automatic mn_lookup_t st_lookup(input logic [2:0] f3);
        mn_lookup_t lk;
        lk.ok = 1'b1;
        case (f3)
            3'd0: lk.mn = MN_SB;
            3'd1: lk.mn = MN_SH;
            3'd2: lk.mn = MN_SW;
            default: begin
                lk.ok = 1'b0;
                lk.mn = MN_ADD;
            end
        endcase
        return lk;
    endfunction

    function automatic mn_lookup_t br_lookup(input logic [2:0] f3);
        mn_lookup_t lk;
        lk.ok = 1'b1;
        case (f3)
            3'd0: lk.mn = MN_BEQ;
            3'd1: lk.mn = MN_BNE;
            3'd4: lk.mn = MN_BLT;
            3'd5: lk.mn = MN_BGE;
            3'd6: lk.mn = MN_BLTU;
            3'd7: lk.mn = MN_BGEU;
            default: begin
                lk.ok = 1'b0;
                lk.mn = MN_ADD;
            end
        endcase
        return lk;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rvdec_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_front: instruction intake and opcode classification
// Accepts instruction words, tags each with its format class from the major
// opcode and holds it in a register stage until the queue takes it.
// ----------------------------------------------------------------------------
module rvdec_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [31:0]         s_instruction_word,
    output logic                     fe_valid,
    input  wire logic                fe_ready,
    output rvdec_pkg::fe_item_t      fe_item
);

    logic                 valid_reg;
    logic                 valid_next;
    rvdec_pkg::fe_item_t  item_reg;
    rvdec_pkg::fmt_t      fmt;

    always_comb begin
        case (s_instruction_word[6:0])
            rvdec_pkg::OPC_OP:     fmt = rvdec_pkg::FMT_OP;
            rvdec_pkg::OPC_OPIMM:  fmt = rvdec_pkg::FMT_OPIMM;
            rvdec_pkg::OPC_LOAD:   fmt = rvdec_pkg::FMT_LOAD;
            rvdec_pkg::OPC_JALR:   fmt = rvdec_pkg::FMT_JALR;
            rvdec_pkg::OPC_SYSTEM: fmt = rvdec_pkg::FMT_SYSTEM;
            rvdec_pkg::OPC_STORE:  fmt = rvdec_pkg::FMT_STORE;
            rvdec_pkg::OPC_BRANCH: fmt = rvdec_pkg::FMT_BRANCH;
            rvdec_pkg::OPC_JAL:    fmt = rvdec_pkg::FMT_JAL;
            rvdec_pkg::OPC_AUIPC:  fmt = rvdec_pkg::FMT_AUIPC;
            rvdec_pkg::OPC_LUI:    fmt = rvdec_pkg::FMT_LUI;
            default:               fmt = rvdec_pkg::FMT_BAD;
        endcase
    end

    // stage is free when empty or when its item leaves this cycle
    assign s_ready = !valid_reg || fe_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.word <= s_instruction_word;
            item_reg.fmt  <= fmt;
        end
    end

    assign fe_valid = valid_reg;
    assign fe_item  = item_reg;

endmodule
`default_nettype wire

// File: rtl/rvdec_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_queue: short queue between front and back end
// Circular buffer of classified items; lets either side stall on its own.
// ----------------------------------------------------------------------------
module rvdec_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire rvdec_pkg::fe_item_t push_item,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output rvdec_pkg::fe_item_t      pop_item
);

    localparam logic [rvdec_pkg::QAW-1:0] LAST_IDX = rvdec_pkg::QAW'(rvdec_pkg::QDEPTH - 1);
    localparam logic [rvdec_pkg::QCW-1:0] FULL_CNT = rvdec_pkg::QCW'(rvdec_pkg::QDEPTH);

    rvdec_pkg::fe_item_t           mem [rvdec_pkg::QDEPTH];
    logic [rvdec_pkg::QAW-1:0]     wr_ptr_reg;
    logic [rvdec_pkg::QAW-1:0]     wr_ptr_next;
    logic [rvdec_pkg::QAW-1:0]     rd_ptr_reg;
    logic [rvdec_pkg::QAW-1:0]     rd_ptr_next;
    logic [rvdec_pkg::QCW-1:0]     count_reg;
    logic [rvdec_pkg::QCW-1:0]     count_next;
    logic                          push;
    logic                          pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rvdec_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_back: field extraction and result register
// Takes classified items from the queue, resolves funct3/funct7, builds the
// immediate and register fields, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module rvdec_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire rvdec_pkg::fe_item_t q_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [5:0]               m_mnemonic,
    output logic [4:0]               m_dest_reg,
    output logic [4:0]               m_src1_reg,
    output logic [4:0]               m_src2_reg,
    output logic signed [31:0]       m_immediate,
    output logic [1:0]               m_status
);

    logic               valid_reg;
    logic               valid_next;
    logic [5:0]         mn_reg;
    logic [4:0]         rd_reg;
    logic [4:0]         rs1_reg;
    logic [4:0]         rs2_reg;
    logic [31:0]        imm_reg;
    logic [1:0]         st_reg;

    logic [5:0]         mn;
    logic [4:0]         d;
    logic [4:0]         s1;
    logic [4:0]         s2;
    logic [31:0]        imm;
    logic [1:0]         st;

    always_comb begin
        logic [31:0]           w;
        logic [2:0]            f3;
        logic [6:0]            f7;
        logic [31:0]           i12;
        rvdec_pkg::mn_lookup_t lk;

        w   = q_item.word;
        f3  = w[14:12];
        f7  = w[31:25];
        i12 = {{20{w[31]}}, w[31:20]};
        lk  = rvdec_pkg::r_lookup(f3);
        mn  = rvdec_pkg::MN_ADD;
        d   = '0;
        s1  = '0;
        s2  = '0;
        imm = '0;
        st  = rvdec_pkg::ST_OK;

        case (q_item.fmt)
            rvdec_pkg::FMT_OP: begin
                mn = lk.mn;
                if (f3 == 3'd0 || f3 == 3'd5) begin
                    if (f7 == rvdec_pkg::F7_ALT) begin
                        mn = lk.mn + 6'd1;
                    end else if (f7 != rvdec_pkg::F7_BASE) begin
                        st = rvdec_pkg::ST_FUNC;
                    end
                end
                d  = w[11:7];
                s1 = w[19:15];
                s2 = w[24:20];
            end
            rvdec_pkg::FMT_OPIMM: begin
                lk = rvdec_pkg::ia_lookup(f3);
                mn = lk.mn;
                d  = w[11:7];
                s1 = w[19:15];
                if (f3 == 3'd1) begin
                    imm = {27'd0, w[24:20]};
                end else if (f3 == 3'd5) begin
                    imm = {27'd0, w[24:20]};
                    if (f7 == rvdec_pkg::F7_ALT) begin
                        mn = rvdec_pkg::MN_SRAI;
                    end else if (f7 != rvdec_pkg::F7_BASE) begin
                        st = rvdec_pkg::ST_FUNC;
                    end
                end else begin
                    imm = i12;
                end
            end
            rvdec_pkg::FMT_LOAD: begin
                lk = rvdec_pkg::ld_lookup(f3);
                if (!lk.ok) begin
                    st = rvdec_pkg::ST_FUNC;
                end
                mn  = lk.mn;
                d   = w[11:7];
                s1  = w[19:15];
                imm = i12;
            end
            rvdec_pkg::FMT_JALR: begin
                if (f3 != 3'd0) begin
                    st = rvdec_pkg::ST_FUNC;
                end
                mn  = rvdec_pkg::MN_JALR;
                d   = w[11:7];
                s1  = w[19:15];
                imm = i12;
            end
            rvdec_pkg::FMT_SYSTEM: begin
                if (f3 != 3'd0) begin
                    st = rvdec_pkg::ST_FUNC;
                end else if (w[31:20] == 12'h000) begin
                    mn = rvdec_pkg::MN_ECALL;
                end else if (w[31:20] == 12'h001) begin
                    mn = rvdec_pkg::MN_EBREAK;
                end else begin
                    st = rvdec_pkg::ST_FUNC;
                end
            end
            rvdec_pkg::FMT_STORE: begin
                lk = rvdec_pkg::st_lookup(f3);
                if (!lk.ok) begin
                    st = rvdec_pkg::ST_FUNC;
                end
                mn  = lk.mn;
                s1  = w[19:15];
                s2  = w[24:20];
                imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            rvdec_pkg::FMT_BRANCH: begin
                lk = rvdec_pkg::br_lookup(f3);
                if (!lk.ok) begin
                    st = rvdec_pkg::ST_FUNC;
                end
                mn  = lk.mn;
                s1  = w[19:15];
                s2  = w[24:20];
                imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            rvdec_pkg::FMT_JAL: begin
                mn  = rvdec_pkg::MN_JAL;
                d   = w[11:7];
                imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            rvdec_pkg::FMT_AUIPC: begin
                mn  = rvdec_pkg::MN_AUIPC;
                d   = w[11:7];
                imm = {w[31:12], 12'd0};
            end
            rvdec_pkg::FMT_LUI: begin
                mn  = rvdec_pkg::MN_LUI;
                d   = w[11:7];
                imm = {w[31:12], 12'd0};
            end
            default: begin
                st = rvdec_pkg::ST_OPCODE;
            end
        endcase

        // zero all fields of a rejected item
        if (st != rvdec_pkg::ST_OK) begin
            mn  = rvdec_pkg::MN_ADD;
            d   = '0;
            s1  = '0;
            s2  = '0;
            imm = '0;
        end
    end

    assign q_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (q_ready) begin
            valid_next = q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            mn_reg  <= mn;
            rd_reg  <= d;
            rs1_reg <= s1;
            rs2_reg <= s2;
            imm_reg <= imm;
            st_reg  <= st;
        end
    end

    assign m_valid     = valid_reg;
    assign m_mnemonic  = mn_reg;
    assign m_dest_reg  = rd_reg;
    assign m_src1_reg  = rs1_reg;
    assign m_src2_reg  = rs2_reg;
    assign m_immediate = imm_reg;
    assign m_status    = st_reg;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != rvdec_pkg::ST_OK) |->
            (m_mnemonic == rvdec_pkg::MN_ADD && m_dest_reg == 5'd0 &&
             m_src1_reg == 5'd0 && m_src2_reg == 5'd0 && m_immediate == 32'sd0))
        else $error("rejected item carries nonzero fields");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == rvdec_pkg::ST_OK || m_status == rvdec_pkg::ST_FUNC ||
                     m_status == rvdec_pkg::ST_OPCODE))
        else $error("undefined status code");

    a_mn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mnemonic <= rvdec_pkg::MN_LUI))
        else $error("mnemonic index out of range");

    a_take_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> m_valid)
        else $error("taken item did not reach the result register");

endmodule
`default_nettype wire

// File: rtl/rv32i_instruction_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder: RV32I instruction decoder
// Decodes one 32-bit instruction word into mnemonic, register numbers,
// immediate and status.
// ----------------------------------------------------------------------------
// Sustains one instruction word per clock cycle with no gaps while m_ready
// stays high. A result passes from the front register, which classifies
// the major opcode, through a two-entry queue between front and back end,
// to the back end, which resolves funct3/funct7 and the immediate into its
// result register; all three are registered. Up to four items can be held
// (front register, two queue entries, result register); once all of them
// are occupied while m_ready stays low, s_ready drops until a result is
// taken. No clearing pass or setup is needed after reset.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [31:0]        s_instruction_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_mnemonic,
    output logic [4:0]              m_dest_reg,
    output logic [4:0]              m_src1_reg,
    output logic [4:0]              m_src2_reg,
    output logic signed [31:0]      m_immediate,
    output logic [1:0]              m_status
);

    logic                 fe_valid;
    logic                 fe_ready;
    rvdec_pkg::fe_item_t  fe_item;
    logic                 q_valid;
    logic                 q_ready;
    rvdec_pkg::fe_item_t  q_item;

    rvdec_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_instruction_word (s_instruction_word),
        .fe_valid           (fe_valid),
        .fe_ready           (fe_ready),
        .fe_item            (fe_item)
    );

    rvdec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_item  (fe_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    rvdec_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mnemonic  (m_mnemonic),
        .m_dest_reg  (m_dest_reg),
        .m_src1_reg  (m_src1_reg),
        .m_src2_reg  (m_src2_reg),
        .m_immediate (m_immediate),
        .m_status    (m_status)
    );

endmodule
`default_nettype wire
